>>> rtl/chk_alu_pkg.sv
// ----------------------------------------------------------------------------
// chk_alu_pkg
// Operation selector and status codes of the overflow-checked signed ALU.
// ----------------------------------------------------------------------------
package chk_alu_pkg;

  typedef enum logic [2:0] {
    ACT_ADD = 3'd0,
    ACT_SUB = 3'd1,
    ACT_MUL = 3'd2,
    ACT_DIV = 3'd3,
    ACT_MOD = 3'd4,
    ACT_SHL = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OVF   = 2'd1,
    ST_DIVZ  = 2'd2,
    ST_SHIFT = 2'd3
  } status_t;

endpackage

>>> rtl/checked_signed_alu.sv
// ----------------------------------------------------------------------------
// checked_signed_alu
// Pipelined overflow-checked signed ALU: add, subtract, multiply, divide,
// non-negative modulo and checked left shift, with a status code per result.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Ports
//  --------  -------------------  ---------------------------------------
//  command   start & !busy        action, operand_a, operand_b
//  result    done (one cycle)     value, status
//
// A transaction may be issued in every clock cycle; busy is never raised.
// Results leave in command order.
// The restoring divider resolves one quotient bit per pipeline stage;
// every operation travels the same stages.
// rst is synchronous and clears only the valid bits of the pipeline.
// The receiver cannot stall, so the pipeline simply advances every cycle.
//
module checked_signed_alu #(
  parameter int DATA_WIDTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         action,
  input  logic signed [63:0] operand_a,
  input  logic signed [63:0] operand_b,
  output logic               done,
  output logic signed [63:0] value,
  output logic [1:0]         status
);

  localparam int W  = DATA_WIDTH;
  localparam int SW = $clog2(W);
  localparam int H  = (W + 1) / 2;
  localparam int PW = 4 * H;

  // One pipeline entry. rem/quo/dvs hold the divider state; quo starts as the
  // dividend magnitude and dvs as the divisor magnitude, which the multiplier
  // also reads. res/st carry the add, subtract, shift and multiply results.
  typedef struct packed {
    logic [2:0]   act;
    logic         sa;
    logic         sb;
    logic         bzero;
    logic [W-1:0] rem;
    logic [W-1:0] quo;
    logic [W-1:0] dvs;
    logic [W-1:0] res;
    logic [1:0]   st;
  } stage_t;

  // The pipeline never holds anything back.
  assign busy = 1'b0;

  // --------------------------------------------------------------------------
  // Input register.
  // --------------------------------------------------------------------------
  logic         a_vld;
  logic [2:0]   a_act;
  logic [W-1:0] a_a;
  logic [W-1:0] a_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    a_act <= action;
    a_a   <= operand_a[W-1:0];
    a_b   <= operand_b[W-1:0];
  end

  // --------------------------------------------------------------------------
  // First stage: add, subtract and shift finish here; magnitudes are formed
  // for the multiplier and the divider.
  // --------------------------------------------------------------------------
  logic [W:0]     sum_w;
  logic [W:0]     dif_w;
  logic [W-1:0]   mag_a;
  logic [W-1:0]   mag_b;
  logic           amt_ok;
  logic [2*W-1:0] sh_full;
  logic           sh_ok;
  stage_t         first_next;

  always_comb begin
    sum_w   = {a_a[W-1], a_a} + {a_b[W-1], a_b};
    dif_w   = {a_a[W-1], a_a} - {a_b[W-1], a_b};
    mag_a   = a_a[W-1] ? (~a_a + 1'b1) : a_a;
    mag_b   = a_b[W-1] ? (~a_b + 1'b1) : a_b;
    amt_ok  = !a_b[W-1] && (a_b < W'(W));
    sh_full = {{W{1'b0}}, a_a} << a_b[SW-1:0];
    // Legal only for a non-negative value whose shifted bits stay below the
    // sign bit.
    sh_ok   = !a_a[W-1] && amt_ok && (sh_full[2*W-1:W-1] == '0);

    first_next.act   = a_act;
    first_next.sa    = a_a[W-1];
    first_next.sb    = a_b[W-1];
    first_next.bzero = (a_b == '0);
    first_next.rem   = '0;
    first_next.quo   = mag_a;
    first_next.dvs   = mag_b;
    first_next.res   = '0;
    first_next.st    = chk_alu_pkg::ST_OK;

    unique case (a_act)
      chk_alu_pkg::ACT_ADD: begin
        if (sum_w[W] != sum_w[W-1]) begin
          first_next.st = chk_alu_pkg::ST_OVF;
        end else begin
          first_next.res = sum_w[W-1:0];
        end
      end
      chk_alu_pkg::ACT_SUB: begin
        if (dif_w[W] != dif_w[W-1]) begin
          first_next.st = chk_alu_pkg::ST_OVF;
        end else begin
          first_next.res = dif_w[W-1:0];
        end
      end
      chk_alu_pkg::ACT_SHL: begin
        if (sh_ok) begin
          first_next.res = sh_full[W-1:0];
        end else begin
          first_next.st = chk_alu_pkg::ST_SHIFT;
        end
      end
      default: begin
        first_next.res = '0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Main pipeline: entry 0 is loaded from the first stage, each later entry
  // adds one quotient bit. The multiplier runs beside entries 1 and 2.
  // --------------------------------------------------------------------------
  logic [W:0] pv;
  stage_t     p [W+1];

  // Multiplier partial products of the two halves, then the full product.
  logic [2*H-1:0] mp_ll;
  logic [2*H-1:0] mp_lh;
  logic [2*H-1:0] mp_hl;
  logic [2*H-1:0] mp_hh;
  logic [2*W-1:0] mprod;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= '0;
    end else begin
      pv <= {pv[W-1:0], a_vld};
    end
  end

  always_ff @(posedge clk) begin
    p[0] <= first_next;
  end

  logic [H-1:0] m_al;
  logic [H-1:0] m_ah;
  logic [H-1:0] m_bl;
  logic [H-1:0] m_bh;
  logic [PW-1:0] msum;

  always_comb begin
    m_al = p[0].quo[H-1:0];
    m_ah = H'(p[0].quo >> H);
    m_bl = p[0].dvs[H-1:0];
    m_bh = H'(p[0].dvs >> H);
    msum = PW'(mp_ll) + (PW'(mp_lh) << H) + (PW'(mp_hl) << H) + (PW'(mp_hh) << (2 * H));
  end

  always_ff @(posedge clk) begin
    mp_ll <= m_al * m_bl;
    mp_lh <= m_al * m_bh;
    mp_hl <= m_ah * m_bl;
    mp_hh <= m_ah * m_bh;
    mprod <= msum[2*W-1:0];
  end

  // Multiply result: a negative product may reach the minimum value, a
  // positive one must stay below it.
  logic           mul_neg;
  logic           mul_ok;
  logic [W-1:0]   mul_res;

  always_comb begin
    mul_neg = p[2].sa ^ p[2].sb;
    if (mul_neg) begin
      mul_ok = (mprod[2*W-1:W-1] == '0) ||
               ((mprod[2*W-1:W-1] == (W+1)'(1)) && (mprod[W-2:0] == '0));
    end else begin
      mul_ok = (mprod[2*W-1:W-1] == '0);
    end
    mul_res = mul_neg ? (~mprod[W-1:0] + 1'b1) : mprod[W-1:0];
  end

  for (genvar i = 0; i < W; i++) begin : g_div
    logic [W:0]   r2;
    logic [W:0]   trial;
    stage_t       nxt;

    always_comb begin
      r2    = {p[i].rem, p[i].quo[W-1]};
      trial = r2 - {1'b0, p[i].dvs};
      nxt   = p[i];
      if (!trial[W]) begin
        nxt.rem = trial[W-1:0];
        nxt.quo = {p[i].quo[W-2:0], 1'b1};
      end else begin
        nxt.rem = r2[W-1:0];
        nxt.quo = {p[i].quo[W-2:0], 1'b0};
      end
      // The finished product joins its transaction on the way into entry 3.
      if ((i == 2) && (p[i].act == chk_alu_pkg::ACT_MUL)) begin
        nxt.res = mul_ok ? mul_res : '0;
        nxt.st  = mul_ok ? chk_alu_pkg::ST_OK : chk_alu_pkg::ST_OVF;
      end
    end

    always_ff @(posedge clk) begin
      p[i+1] <= nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Last stage: signs are applied to quotient and remainder.
  // --------------------------------------------------------------------------
  logic [W-1:0] fin_res;
  logic [1:0]   fin_st;
  logic         q_neg;

  always_comb begin
    q_neg   = p[W].sa ^ p[W].sb;
    fin_res = p[W].res;
    fin_st  = p[W].st;
    unique case (p[W].act)
      chk_alu_pkg::ACT_DIV: begin
        if (p[W].bzero) begin
          fin_res = '0;
          fin_st  = chk_alu_pkg::ST_DIVZ;
        end else if (!q_neg && p[W].quo[W-1]) begin
          // Only the minimum value divided by minus one lands here.
          fin_res = '0;
          fin_st  = chk_alu_pkg::ST_OVF;
        end else begin
          fin_res = q_neg ? (~p[W].quo + 1'b1) : p[W].quo;
          fin_st  = chk_alu_pkg::ST_OK;
        end
      end
      chk_alu_pkg::ACT_MOD: begin
        if (p[W].bzero) begin
          fin_res = '0;
          fin_st  = chk_alu_pkg::ST_DIVZ;
        end else begin
          // A negative remainder is moved up by the divisor magnitude.
          fin_res = (p[W].sa && (p[W].rem != '0)) ? (p[W].dvs - p[W].rem) : p[W].rem;
          fin_st  = chk_alu_pkg::ST_OK;
        end
      end
      default: begin
        fin_res = p[W].res;
        fin_st  = p[W].st;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= pv[W];
    end
  end

  always_ff @(posedge clk) begin
    value  <= 64'(signed'(fin_res));
    status <= fin_st;
  end

endmodule
